@@ hdl/ssb_pkg.sv @@
// ----------------------------------------------------------------------------
// ssb_pkg
// Shared types, constants and helpers for the scaled sprite blitter.
// ----------------------------------------------------------------------------
package ssb_pkg;

    localparam int ScreenW  = 320;
    localparam int ScreenH  = 240;
    localparam int TexDepth = 4096;
    localparam int TexAw    = 12;

    typedef enum logic [2:0] {
        REG_LEFT   = 3'd0,
        REG_TOP    = 3'd1,
        REG_WIDTH  = 3'd2,
        REG_HEIGHT = 3'd3,
        REG_TEX_W  = 3'd4,
        REG_TEX_H  = 3'd5,
        REG_MODE   = 3'd6,
        REG_WEIGHT = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_OPAQUE = 2'd0,
        MODE_KEY    = 2'd1,
        MODE_BLEND  = 2'd2,
        MODE_BLEND3 = 2'd3
    } draw_mode_t;

    typedef struct packed {
        logic       command;
        logic [11:0] texel_index;
        logic [8:0] pixel_x;
        logic [7:0] pixel_y;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } in_word_t;

    typedef struct packed {
        logic       write_enable;
        logic [8:0] out_x;
        logic [7:0] out_y;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } out_word_t;

    typedef struct packed {
        logic signed [12:0] left;
        logic signed [12:0] top;
        logic [11:0]        width;
        logic [11:0]        height;
        logic [6:0]         tex_w;
        logic [6:0]         tex_h;
        logic [1:0]         mode;
        logic [8:0]         weight;
    } cfg_t;

    // one blended channel: (t*(256-w) + d*w + 128) >> 8
    function automatic logic [7:0] mix(input logic [7:0] t, input logic [7:0] d,
                                       input logic [8:0] w);
        logic [17:0] s;
        s = 18'(t) * 18'(9'd256 - w) + 18'(d) * 18'(w) + 18'd128;
        return s[15:8];
    endfunction

endpackage

@@ hdl/ssb_div.sv @@
// ----------------------------------------------------------------------------
// ssb_div
// Pipelined restoring divider: 19-bit dividend by 12-bit divisor, 7-bit
// quotient (quotient always < 128 because offset < size and the texture
// size fits in 7 bits). One bit per stage.
// ----------------------------------------------------------------------------
module ssb_div
(
    input  logic        clk,
    input  logic        en,
    input  logic [18:0] num,
    input  logic [11:0] den,
    output logic [6:0]  quo
);

    logic [18:0] rem_reg [0:7];
    logic [11:0] den_reg [0:7];
    logic [6:0]  q_reg   [0:7];

    // stage 0 loads, stages 1..7 each retire one quotient bit (bit 6 down to 0)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
        end
    end

    for (genvar s = 1; s < 8; s++)
    begin : g_stage
        localparam int Sh = 7 - s;
        logic [18:0] trial;
        logic        fit;
        assign trial = 19'(den_reg[s-1]) << Sh;
        assign fit   = (rem_reg[s-1] >= trial);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= fit ? rem_reg[s-1] - trial : rem_reg[s-1];
                den_reg[s] <= den_reg[s-1];
                q_reg[s]   <= q_reg[s-1] | (fit ? 7'(1 << Sh) : 7'd0);
            end
        end
    end

    assign quo = q_reg[7];

endmodule

@@ hdl/ssb_tex_mem.sv @@
// ----------------------------------------------------------------------------
// ssb_tex_mem
// Texture store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ssb_tex_mem
(
    input  logic        clk,
    input  logic        we,
    input  logic [11:0] waddr,
    input  logic [23:0] wdata,
    input  logic        re,
    input  logic [11:0] raddr,
    output logic [23:0] rdata
);

    logic [23:0] mem [0:ssb_pkg::TexDepth-1];

    // write texel
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // read texel, hold while stalled
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

@@ hdl/scaled_sprite_blitter_unit.sv @@
// ----------------------------------------------------------------------------
// scaled_sprite_blitter_unit
// Sprite blitter: texture load, scaled lookup, color key and blend.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | word
//  in      | in  | in_valid/in_stall   | ssb_pkg::in_word_t
//  out     | out | out_valid/out_stall | ssb_pkg::out_word_t
//  cfg     | in  | cfg_we              | cfg_index / cfg_data
//
// One word per cycle sustained while the output is not stalled; after accept a
// draw passes the offset product register, the divider (load and seven bit
// stages), the address multiply and the memory read; key and blend feed the
// output register. Loads yield no word and write the texture as they pass the
// read stage, so draws see loads in order. The pipe advances as a whole when
// the output register is free; reset clears the valid bits and restores the
// configuration defaults, the texture is undefined until loaded.
// ----------------------------------------------------------------------------
module scaled_sprite_blitter_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ssb_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ssb_pkg::out_word_t  out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [12:0]         cfg_data
);

    localparam int Depth = 11;

    ssb_pkg::cfg_t cfg_reg;
    logic          adv;
    logic          acc;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{left: '0, top: '0, width: 12'd1, height: 12'd1,
                         tex_w: 7'd64, tex_h: 7'd64, mode: '0, weight: '0};
        end
        else if (cfg_we)
        begin
            case (ssb_pkg::reg_idx_t'(cfg_index))
                ssb_pkg::REG_LEFT:   cfg_reg.left   <= cfg_data;
                ssb_pkg::REG_TOP:    cfg_reg.top    <= cfg_data;
                ssb_pkg::REG_WIDTH:  cfg_reg.width  <= cfg_data[11:0];
                ssb_pkg::REG_HEIGHT: cfg_reg.height <= cfg_data[11:0];
                ssb_pkg::REG_TEX_W:  cfg_reg.tex_w  <= cfg_data[6:0];
                ssb_pkg::REG_TEX_H:  cfg_reg.tex_h  <= cfg_data[6:0];
                ssb_pkg::REG_MODE:   cfg_reg.mode   <= cfg_data[1:0];
                ssb_pkg::REG_WEIGHT: cfg_reg.weight <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // whole pipe moves when the output register is empty or being taken
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;
    assign acc      = in_valid && adv;

    // stage 0: window test and offset products
    logic signed [13:0] dx, dy;
    logic               in_rect;
    assign dx = 14'(signed'({5'd0, in_data.pixel_x})) - 14'(cfg_reg.left);
    assign dy = 14'(signed'({6'd0, in_data.pixel_y})) - 14'(cfg_reg.top);
    assign in_rect = !dx[13] && (dx < 14'(signed'({2'b0, cfg_reg.width})))
                  && !dy[13] && (dy < 14'(signed'({2'b0, cfg_reg.height})))
                  && (32'(in_data.pixel_x) < ssb_pkg::ScreenW)
                  && (32'(in_data.pixel_y) < ssb_pkg::ScreenH);

    logic [18:0] nx_reg, ny_reg;
    logic [11:0] wx_reg, wy_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_reg <= 19'(dx[11:0]) * 19'(cfg_reg.tex_w);
            ny_reg <= 19'(dy[11:0]) * 19'(cfg_reg.tex_h);
            wx_reg <= cfg_reg.width;
            wy_reg <= cfg_reg.height;
        end
    end

    logic [6:0] tx, ty;
    ssb_div u_div_x (.clk(clk), .en(adv), .num(nx_reg), .den(wx_reg), .quo(tx));
    ssb_div u_div_y (.clk(clk), .en(adv), .num(ny_reg), .den(wy_reg), .quo(ty));

    // side-band: valid, rectangle flag and word ride along (index 0 = stage 0 reg)
    logic              v_reg   [0:Depth-1];
    logic              ins_reg [0:Depth-1];
    ssb_pkg::in_word_t w_reg   [0:Depth-1];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Depth; i++)
                v_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= acc;
            for (int i = 1; i < Depth; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ins_reg[0] <= in_rect;
            w_reg[0]   <= in_data;
            for (int i = 1; i < Depth; i++)
            begin
                ins_reg[i] <= ins_reg[i-1];
                w_reg[i]   <= w_reg[i-1];
            end
        end
    end

    // stage 9: texel address (divider output valid with side-band index 8)
    logic [13:0] addr_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            addr_reg <= 14'(ty) * 14'(cfg_reg.tex_w) + 14'(tx);
    end

    // stage 10: memory read and load write; out-of-range address reads black
    logic [23:0] texel;
    logic        oob_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            oob_reg <= (32'(addr_reg) >= ssb_pkg::TexDepth);
    end

    ssb_tex_mem u_mem (
        .clk   (clk),
        .we    (adv && v_reg[9] && !w_reg[9].command),
        .waddr (w_reg[9].texel_index[ssb_pkg::TexAw-1:0]),
        .wdata ({w_reg[9].in_red, w_reg[9].in_green, w_reg[9].in_blue}),
        .re    (adv),
        .raddr (addr_reg[ssb_pkg::TexAw-1:0]),
        .rdata (texel)
    );

    // stage 11: key, blend and output register
    ssb_pkg::in_word_t pw;
    logic [23:0]       tv;
    logic              black;
    logic [8:0]        wsat;
    ssb_pkg::out_word_t res;
    assign pw    = w_reg[10];
    assign tv    = oob_reg ? 24'd0 : texel;
    assign black = (tv == 24'd0);
    assign wsat  = cfg_reg.weight[8] ? 9'd256 : cfg_reg.weight;

    always_comb
    begin
        res = '{write_enable: 1'b0, out_x: pw.pixel_x, out_y: pw.pixel_y,
                out_red: pw.in_red, out_green: pw.in_green, out_blue: pw.in_blue};
        if (ins_reg[10])
        begin
            case (ssb_pkg::draw_mode_t'(cfg_reg.mode))
                ssb_pkg::MODE_OPAQUE:
                begin
                    res.write_enable = 1'b1;
                    {res.out_red, res.out_green, res.out_blue} = tv;
                end
                ssb_pkg::MODE_KEY:
                begin
                    if (!black)
                    begin
                        res.write_enable = 1'b1;
                        {res.out_red, res.out_green, res.out_blue} = tv;
                    end
                end
                default:
                begin
                    if (!black)
                    begin
                        res.write_enable = 1'b1;
                        res.out_red   = ssb_pkg::mix(tv[23:16], pw.in_red, wsat);
                        res.out_green = ssb_pkg::mix(tv[15:8], pw.in_green, wsat);
                        res.out_blue  = ssb_pkg::mix(tv[7:0], pw.in_blue, wsat);
                    end
                end
            endcase
        end
    end

    logic out_valid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v_reg[10] && w_reg[10].command;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
            out_data <= res;
    end
    assign out_valid = out_valid_reg;

endmodule

@@ hdl/ssb_checker.sv @@
// ----------------------------------------------------------------------------
// ssb_checker
// Port-level checks for the sprite blitter, bound to the top level.
// ----------------------------------------------------------------------------
module ssb_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input ssb_pkg::out_word_t out_data
);

    // stall input only when an output word is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with no output backpressure");

    // stalled output word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled output word changed");

    // a skipped pixel off the screen never writes
    a_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.write_enable) |->
        (32'(out_data.out_x) < ssb_pkg::ScreenW && 32'(out_data.out_y) < ssb_pkg::ScreenH))
        else $error("write outside screen");

endmodule

bind scaled_sprite_blitter_unit ssb_checker u_ssb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

@@ dv/ssb_checker.sv @@
// ----------------------------------------------------------------------------
// ssb_scoreboard
// Watches the input, output and register ports of the sprite blitter. It
// keeps its own texture store and register copy, predicts the output word
// of each accepted draw and compares every output word against the oldest
// prediction.
// ----------------------------------------------------------------------------
module ssb_scoreboard
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  ssb_pkg::in_word_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  ssb_pkg::out_word_t out_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [12:0]        cfg_data,
    output int                 errors,
    output int                 pending
);

    logic [23:0]         texels [ssb_pkg::TexDepth];
    int                  spr_left;
    int                  spr_top;
    int                  spr_w;
    int                  spr_h;
    int                  tex_w;
    int                  tex_h;
    ssb_pkg::draw_mode_t mode;
    int                  weight;
    ssb_pkg::out_word_t  pixel_q [$];

    // blend one channel toward the destination by weight w
    function automatic logic [7:0] blend_channel(input int t, input int d, input int w);
        int s;
        s = (t * (256 - w) + d * w + 128) >> 8;
        return s[7:0];
    endfunction

    // compute the output word for one draw
    function automatic ssb_pkg::out_word_t draw_pixel(input ssb_pkg::in_word_t w);
        ssb_pkg::out_word_t o;
        int                 x;
        int                 y;
        int                 tx;
        int                 ty;
        int                 addr;
        int                 wt;
        logic [23:0]        texel;
        x = w.pixel_x;
        y = w.pixel_y;
        o.write_enable = 1'b0;
        o.out_x        = w.pixel_x;
        o.out_y        = w.pixel_y;
        o.out_red      = w.in_red;
        o.out_green    = w.in_green;
        o.out_blue     = w.in_blue;
        if (x >= spr_left && x < spr_left + spr_w && y >= spr_top && y < spr_top + spr_h
            && x < ssb_pkg::ScreenW && y < ssb_pkg::ScreenH)
        begin
            tx    = ((x - spr_left) * tex_w) / spr_w;
            ty    = ((y - spr_top) * tex_h) / spr_h;
            addr  = ty * tex_w + tx;
            texel = (addr < ssb_pkg::TexDepth) ? texels[addr] : 24'd0;
            wt    = (weight > 256) ? 256 : weight;
            if (mode == ssb_pkg::MODE_OPAQUE
                || (mode == ssb_pkg::MODE_KEY && texel != 24'd0))
            begin
                o.write_enable = 1'b1;
                o.out_red      = texel[23:16];
                o.out_green    = texel[15:8];
                o.out_blue     = texel[7:0];
            end
            else if (mode != ssb_pkg::MODE_KEY && texel != 24'd0)
            begin
                o.write_enable = 1'b1;
                o.out_red      = blend_channel(texel[23:16], w.in_red, wt);
                o.out_green    = blend_channel(texel[15:8], w.in_green, wt);
                o.out_blue     = blend_channel(texel[7:0], w.in_blue, wt);
            end
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ssb_pkg::out_word_t e;
        if (!rst_n) begin
            spr_left = 0;
            spr_top  = 0;
            spr_w    = 1;
            spr_h    = 1;
            tex_w    = 64;
            tex_h    = 64;
            mode     = ssb_pkg::MODE_OPAQUE;
            weight   = 0;
            errors   = 0;
            pixel_q.delete();
        end else begin
            // track register writes
            if (cfg_we) begin
                case (ssb_pkg::reg_idx_t'(cfg_index))
                    ssb_pkg::REG_LEFT:   spr_left = $signed(cfg_data);
                    ssb_pkg::REG_TOP:    spr_top  = $signed(cfg_data);
                    ssb_pkg::REG_WIDTH:  spr_w    = cfg_data[11:0];
                    ssb_pkg::REG_HEIGHT: spr_h    = cfg_data[11:0];
                    ssb_pkg::REG_TEX_W:  tex_w    = cfg_data[6:0];
                    ssb_pkg::REG_TEX_H:  tex_h    = cfg_data[6:0];
                    ssb_pkg::REG_MODE:   mode     = ssb_pkg::draw_mode_t'(cfg_data[1:0]);
                    ssb_pkg::REG_WEIGHT: weight   = cfg_data[8:0];
                    default: ;
                endcase
            end
            // store texels, predict draws
            if (in_valid && !in_stall) begin
                if (!in_data.command)
                    texels[in_data.texel_index] = {in_data.in_red, in_data.in_green,
                                                   in_data.in_blue};
                else
                    pixel_q.push_back(draw_pixel(in_data));
            end
            // compare output words
            if (out_valid && !out_stall) begin
                if (pixel_q.size() == 0) begin
                    $error("unexpected output word %h", out_data);
                    errors++;
                end else begin
                    e = pixel_q.pop_front();
                    if (out_data.write_enable !== e.write_enable) begin
                        $error("write_enable: expected %h, got %h", e.write_enable,
                               out_data.write_enable);
                        errors++;
                    end
                    if (out_data.out_x !== e.out_x) begin
                        $error("out_x: expected %0d, got %0d", e.out_x, out_data.out_x);
                        errors++;
                    end
                    if (out_data.out_y !== e.out_y) begin
                        $error("out_y: expected %0d, got %0d", e.out_y, out_data.out_y);
                        errors++;
                    end
                    if (out_data.out_red !== e.out_red) begin
                        $error("out_red: expected %h, got %h", e.out_red, out_data.out_red);
                        errors++;
                    end
                    if (out_data.out_green !== e.out_green) begin
                        $error("out_green: expected %h, got %h", e.out_green,
                               out_data.out_green);
                        errors++;
                    end
                    if (out_data.out_blue !== e.out_blue) begin
                        $error("out_blue: expected %h, got %h", e.out_blue,
                               out_data.out_blue);
                        errors++;
                    end
                end
            end
        end
        pending = pixel_q.size();
    end

endmodule

@@ dv/scaled_sprite_blitter_unit_tb.sv @@
// ----------------------------------------------------------------------------
// scaled_sprite_blitter_unit_tb
// Loads the low texture entries, then runs a series of register settings
// (edges, empty and clipped rectangles, zero and single-texel textures, every
// draw mode and weight extremes), each with corner draws and random words,
// under random sender gaps and receiver stalls. Checking is in ssb_scoreboard.
// ----------------------------------------------------------------------------
module scaled_sprite_blitter_unit_tb;

    localparam int CycleLimit = 1000000;
    localparam int DrainWait  = 20;
    localparam int TexFill    = 256;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    ssb_pkg::in_word_t  in_data;
    logic               out_valid;
    logic               out_stall;
    ssb_pkg::out_word_t out_data;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [12:0]        cfg_data;
    int                 errors;
    int                 pending;
    int                 cycles;
    int                 burst_left;
    int                 stall_left;
    int                 stall_kind;
    int                 cur_left;
    int                 cur_top;
    int                 cur_w;
    int                 cur_h;

    scaled_sprite_blitter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ssb_scoreboard u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver stall pattern: none, light or heavy, for random stretches
    always @(posedge clk)
    begin
        if (stall_left == 0) begin
            stall_kind = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_kind)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("scaled_sprite_blitter_unit_tb: FAIL");
            $finish;
        end
    end

    // send one word; called and returns at a rising edge
    task automatic send_word(input ssb_pkg::in_word_t w);
        logic st;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= w;
        forever begin
            @(negedge clk);
            st = in_stall;
            @(posedge clk);
            if (!st) break;
        end
    endtask

    task automatic send_draw(input int x, input int y);
        ssb_pkg::in_word_t w;
        w.command     = 1'b1;
        w.texel_index = 12'($urandom);
        w.pixel_x     = 9'(x);
        w.pixel_y     = 8'(y);
        w.in_red      = 8'($urandom);
        w.in_green    = 8'($urandom);
        w.in_blue     = 8'($urandom);
        send_word(w);
    endtask

    task automatic send_load(input int idx);
        ssb_pkg::in_word_t w;
        w.command     = 1'b0;
        w.texel_index = 12'(idx);
        w.pixel_x     = 9'($urandom);
        w.pixel_y     = 8'($urandom);
        if ($urandom_range(0, 7) == 0) begin
            w.in_red   = 8'd0;
            w.in_green = 8'd0;
            w.in_blue  = 8'd0;
        end else begin
            w.in_red   = 8'($urandom);
            w.in_green = 8'($urandom);
            w.in_blue  = 8'($urandom);
        end
        send_word(w);
    endtask

    // write one register
    task automatic write_reg(input ssb_pkg::reg_idx_t idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 13'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // idle the block, set the registers, then send corner and random words;
    // every setting keeps texel addresses below TexFill or at or above TexDepth
    task automatic run_phase(input int l, input int t, input int w, input int h,
                             input int tw, input int th, input ssb_pkg::draw_mode_t m,
                             input int wt, input int n);
        int lo_x;
        int hi_x;
        int lo_y;
        int hi_y;
        int x;
        int y;
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DrainWait) @(posedge clk);
        write_reg(ssb_pkg::REG_LEFT, l);
        @(posedge clk);
        write_reg(ssb_pkg::REG_TOP, t);
        write_reg(ssb_pkg::REG_WIDTH, w);
        write_reg(ssb_pkg::REG_HEIGHT, h);
        write_reg(ssb_pkg::REG_TEX_W, tw);
        write_reg(ssb_pkg::REG_TEX_H, th);
        write_reg(ssb_pkg::REG_MODE, m);
        write_reg(ssb_pkg::REG_WEIGHT, wt);
        @(posedge clk);
        cur_left = l;
        cur_top  = t;
        cur_w    = w;
        cur_h    = h;
        // corners of the screen, the field limits and the sprite origin
        send_draw(0, 0);
        send_draw(ssb_pkg::ScreenW - 1, ssb_pkg::ScreenH - 1);
        send_draw(511, 255);
        send_draw((l < 0) ? 0 : l, (t < 0) ? 0 : t);
        lo_x = (cur_left < 0) ? 0 : cur_left;
        hi_x = (cur_left + cur_w - 1 > 511) ? 511 : cur_left + cur_w - 1;
        lo_y = (cur_top < 0) ? 0 : cur_top;
        hi_y = (cur_top + cur_h - 1 > 255) ? 255 : cur_top + cur_h - 1;
        repeat (n) begin
            if ($urandom_range(0, 9) == 0) begin
                send_load($urandom_range(0, ssb_pkg::TexDepth - 1));
            end else begin
                // mostly aim inside the sprite
                if (lo_x <= hi_x && lo_x <= 511 && $urandom_range(0, 4) != 0)
                    x = $urandom_range(hi_x, lo_x);
                else
                    x = $urandom_range(0, 511);
                if (lo_y <= hi_y && lo_y <= 255 && $urandom_range(0, 4) != 0)
                    y = $urandom_range(hi_y, lo_y);
                else
                    y = $urandom_range(0, 255);
                send_draw(x, y);
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_index  = ssb_pkg::REG_LEFT;
        cfg_data   = '0;
        burst_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the low texture entries so no draw reads an unwritten texel
        for (int i = 0; i < TexFill; i++)
            send_load(i);

        run_phase(0, 0, 1, 1, 64, 64, ssb_pkg::MODE_OPAQUE, 0, 20);
        run_phase(-4096, -4096, 4095, 4095, 64, 64, ssb_pkg::MODE_OPAQUE, 0, 70);
        run_phase(10, 20, 100, 60, 16, 8, ssb_pkg::MODE_KEY, 0, 70);
        run_phase(-50, -30, 200, 150, 16, 16, ssb_pkg::MODE_BLEND, 0, 70);
        run_phase(100, 100, 4095, 4095, 1, 1, ssb_pkg::MODE_BLEND, 256, 60);
        run_phase(4095, 4095, 1, 1, 64, 64, ssb_pkg::MODE_OPAQUE, 0, 30);
        run_phase(0, 0, 0, 0, 64, 64, ssb_pkg::MODE_OPAQUE, 0, 30);
        run_phase(5, 5, 300, 200, 0, 0, ssb_pkg::MODE_BLEND3, 511, 70);
        run_phase(0, 0, ssb_pkg::ScreenW, ssb_pkg::ScreenH, 127, 2, ssb_pkg::MODE_KEY, 0, 70);
        run_phase(300, 200, 50, 50, 7, 33, ssb_pkg::MODE_BLEND, 128, 70);
        repeat (8) begin
            run_phase($urandom_range(0, 1) ? int'($urandom_range(0, 330))
                                           : -int'($urandom_range(0, 200)),
                      $urandom_range(0, 1) ? int'($urandom_range(0, 250))
                                           : -int'($urandom_range(0, 200)),
                      $urandom_range(1, 400), $urandom_range(1, 300),
                      $urandom_range(1, 16), $urandom_range(1, 16),
                      ssb_pkg::draw_mode_t'($urandom_range(0, 3)),
                      $urandom_range(0, 300), 40);
        end

        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DrainWait) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("scaled_sprite_blitter_unit_tb: PASS");
        else
            $display("scaled_sprite_blitter_unit_tb: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/ssb_pkg.sv
hdl/ssb_div.sv
hdl/ssb_tex_mem.sv
hdl/scaled_sprite_blitter_unit.sv
hdl/ssb_checker.sv
dv/ssb_checker.sv
dv/scaled_sprite_blitter_unit_tb.sv
